// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and types for the serial command frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned MAX_PAYLOAD = 10;

  localparam logic [7:0] SYNC_BYTE  = 8'hAA;
  localparam logic [7:0] END_BYTE   = 8'h0A;
  localparam logic [7:0] CMD_NACK_A = 8'h55;
  localparam logic [7:0] CMD_READ   = 8'h56;
  localparam logic [7:0] CMD_SCHED  = 8'h15;
  localparam logic [7:0] CMD_PILL   = 8'h07;
  localparam logic [7:0] CMD_NACK_B = 8'h26;
  localparam logic [7:0] READ_KEY   = 8'h52;

  localparam logic [3:0] LEN_READ  = 4'd1;
  localparam logic [3:0] LEN_SCHED = 4'd4;
  localparam logic [3:0] LEN_PILL  = 4'd2;

  // Byte slots inside a frame
  localparam logic [3:0] POS_HUNT    = 4'd0;
  localparam logic [3:0] POS_CMD     = 4'd1;
  localparam logic [3:0] POS_LEN     = 4'd2;
  localparam logic [3:0] POS_PAYLOAD = 4'd3;

  typedef enum logic [2:0] {
    V_BAD_END   = 3'd0,
    V_BAD_SUM   = 3'd1,
    V_READ      = 3'd2,
    V_SCHED     = 3'd3,
    V_PILL      = 3'd4,
    V_UNKNOWN   = 3'd5,
    V_WRONG_LEN = 3'd6
  } verdict_t;

  function automatic logic known_command(input logic [7:0] b);
    return (b == CMD_NACK_A) || (b == CMD_READ) || (b == CMD_SCHED) ||
           (b == CMD_PILL) || (b == CMD_NACK_B);
  endfunction

endpackage

// ===== rtl/serial_command_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// serial_command_frame_receiver
// Parses sync/command/length/payload/checksum/terminator frames from a byte
// stream and reports one verdict per completed frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received serial byte per word (valid/ready).
//   out_* : one verdict word per completed frame, with command, length and
//           the first four payload bytes (zero where the frame has fewer).
//   Frames: 0xAA, command, length L (0..10), L payload bytes, 8-bit sum of
//   the payload, 0x0A. Unknown commands and lengths above 10 drop the frame
//   silently; bytes outside a frame are ignored.
// Timing:
//   A byte is taken every cycle while the input register is not stalled. Each
//   accepted byte is held in the input register, where the frame state advances;
//   the terminator byte's verdict is written into the output register when that
//   byte is consumed there, and out_valid is driven from the output register.
// Reset:
//   rst_n (synchronous, low) returns the parser to sync hunting and empties
//   both registers.
// Stall:
//   While out_ready is low a pending verdict holds; bytes that produce no
//   verdict keep flowing, and the input register stalls only when a second
//   verdict is ready to be written behind the held one.
// ----------------------------------------------------------------------------
module serial_command_frame_receiver
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_verdict,
  output logic [7:0] out_command_code,
  output logic [3:0] out_payload_length,
  output logic [7:0] out_payload_first,
  output logic [7:0] out_payload_second,
  output logic [7:0] out_payload_third,
  output logic [7:0] out_payload_fourth
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  logic [3:0] pos_r, pos_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [3:0] len_r, len_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       match_r, match_nxt;
  logic [7:0] head_r [4];

  logic       out_valid_r;
  verdict_t   verdict_r, verdict_nxt;
  logic [7:0] ocmd_r;
  logic [3:0] olen_r;
  logic [7:0] opay_r [4];
  logic [7:0] opay_nxt [4];

  logic       emit;
  logic       head_we;
  logic [3:0] pay_idx;
  logic [3:0] sum_pos;
  logic       out_free;
  logic       fire;

  assign out_free = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && (!emit || out_free);
  assign in_ready = !s1_valid_r || fire;
  assign pay_idx  = pos_r - POS_PAYLOAD;
  assign sum_pos  = len_r + POS_PAYLOAD;

  // Frame state advance for the byte in the input register
  always_comb begin
    pos_nxt   = pos_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    match_nxt = match_r;
    emit      = 1'b0;
    head_we   = 1'b0;
    priority if (pos_r == POS_HUNT) begin
      if (s1_byte_r == SYNC_BYTE) pos_nxt = POS_CMD;
    end else if (pos_r == POS_CMD) begin
      if (known_command(s1_byte_r)) begin
        cmd_nxt = s1_byte_r;
        pos_nxt = POS_LEN;
      end else begin
        pos_nxt = POS_HUNT;
      end
    end else if (pos_r == POS_LEN) begin
      if (s1_byte_r > 8'(MAX_PAYLOAD)) begin
        pos_nxt = POS_HUNT;
      end else begin
        len_nxt   = s1_byte_r[3:0];
        sum_nxt   = '0;
        match_nxt = 1'b0;
        pos_nxt   = POS_PAYLOAD;
      end
    end else if (pos_r < sum_pos) begin
      head_we = (pay_idx < 4'd4);
      sum_nxt = sum_r + s1_byte_r;
      pos_nxt = pos_r + 4'd1;
    end else if (pos_r == sum_pos) begin
      match_nxt = (s1_byte_r == sum_r);
      pos_nxt   = pos_r + 4'd1;
    end else begin
      emit    = 1'b1;
      pos_nxt = POS_HUNT;
    end
  end

  // Verdict and output payload for the terminator slot
  always_comb begin
    priority if (s1_byte_r != END_BYTE) begin
      verdict_nxt = V_BAD_END;
    end else if (!match_r) begin
      verdict_nxt = V_BAD_SUM;
    end else if (cmd_r == CMD_READ) begin
      verdict_nxt = (len_r == LEN_READ && head_r[0] == READ_KEY) ? V_READ : V_WRONG_LEN;
    end else if (cmd_r == CMD_SCHED) begin
      verdict_nxt = (len_r == LEN_SCHED) ? V_SCHED : V_WRONG_LEN;
    end else if (cmd_r == CMD_PILL) begin
      verdict_nxt = (len_r == LEN_PILL) ? V_PILL : V_WRONG_LEN;
    end else begin
      verdict_nxt = V_UNKNOWN;
    end
    for (int k = 0; k < 4; k++) begin
      opay_nxt[k] = (len_r > 4'(k)) ? head_r[k] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= POS_HUNT;
      cmd_r       <= '0;
      len_r       <= '0;
      sum_r       <= '0;
      match_r     <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (fire) begin
        pos_r   <= pos_nxt;
        cmd_r   <= cmd_nxt;
        len_r   <= len_nxt;
        sum_r   <= sum_nxt;
        match_r <= match_nxt;
      end
      if (fire && emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) s1_byte_r <= in_rx_byte;
    if (fire && head_we) head_r[pay_idx[1:0]] <= s1_byte_r;
    if (fire && emit) begin
      verdict_r <= verdict_nxt;
      ocmd_r    <= cmd_r;
      olen_r    <= len_r;
      opay_r    <= opay_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = verdict_r;
  assign out_command_code   = ocmd_r;
  assign out_payload_length = olen_r;
  assign out_payload_first  = opay_r[0];
  assign out_payload_second = opay_r[1];
  assign out_payload_third  = opay_r[2];
  assign out_payload_fourth = opay_r[3];

endmodule

// ===== rtl/sfr_checker.sv =====
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks for the serial command frame receiver.
// ----------------------------------------------------------------------------
module sfr_checker
  import sfr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_verdict,
  input logic [7:0] out_command_code,
  input logic [3:0] out_payload_length,
  input logic [7:0] out_payload_first,
  input logic [7:0] out_payload_second
);

  // hold a stalled verdict word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict) &&
    $stable(out_command_code) && $stable(out_payload_length))
    else $error("stalled verdict word changed");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload_length <= 4'(MAX_PAYLOAD))
    else $error("payload length above maximum");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == V_READ |->
    out_command_code == CMD_READ && out_payload_length == LEN_READ &&
    out_payload_first == READ_KEY)
    else $error("read request verdict on a frame that does not qualify");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_length < 4'd2 |-> out_payload_second == 8'h00)
    else $error("absent payload byte not zero");

  a_cmd_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> known_command(out_command_code))
    else $error("verdict for a frame with unknown command");

endmodule

bind serial_command_frame_receiver sfr_checker u_sfr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_verdict        (out_verdict),
  .out_command_code   (out_command_code),
  .out_payload_length (out_payload_length),
  .out_payload_first  (out_payload_first),
  .out_payload_second (out_payload_second)
);
